/* design/vsirl_pkg.sv */
package vsirl_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 7;

  // Operation codes; the spare code behaves as a lookup.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // Per-cell control, driven from the top level.
  typedef struct packed {
    logic cmp_en;   // latch compare result for a new transaction
    logic load_en;  // take the incoming value (append)
    logic shift_en; // take the upper neighbor's value (compaction)
  } cell_ctrl_t;

endpackage

/* design/value_set_insert_remove_lookup_top.sv */
// Ordered set of distinct 32-bit values held in a chain of CAPACITY cells.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; in_kind selects lookup, insert or remove (the spare code is
// a lookup) and in_value carries the value.
// In each transaction, first every cell compares its
// entry against the value and registers a hit; then the hits are
// combined, the operation is applied (append at the fill count, or shift
// every cell above the hit down by one place) and busy is high.
// No new transaction is taken while busy is high; the fixed
// compare-then-update pass through the cell chain is the reason.
// Result channel: out_valid is high for exactly one cycle; it is registered
// from busy, and the result is taken at the edge that ends that pulse,
// with out_found, out_entry_count and out_full_refused.
// The receiver cannot stall; a result is never held, and the next
// transaction may be taken while a result is on the ports.
// Reset (synchronous, rst_n low) empties the set by clearing the fill count;
// entry contents are not cleared, cells at or above the count are never
// reported as hits.
module value_set_insert_remove_lookup_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [vsirl_pkg::KIND_W-1:0]         in_kind,
  input  logic [vsirl_pkg::VAL_W-1:0]          in_value,
  output logic                                 out_valid,
  output logic                                 out_found,
  output logic [vsirl_pkg::COUNT_W-1:0]        out_entry_count,
  output logic                                 out_full_refused
);
  import vsirl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Transaction registers
  logic              busy_r;
  kind_t             kind_r;
  logic [VAL_W-1:0]  value_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;

  // Result registers
  logic               out_valid_r;
  logic               out_found_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_refused_r;

  logic                accept;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] past_hit;   // a hit at or below this cell
  logic                found;
  logic                full;
  logic                do_insert;
  logic                do_remove;
  logic                refused;

  logic [VAL_W-1:0]    cell_data [CAPACITY];
  logic [VAL_W-1:0]    cell_key;

  assign accept   = start && !busy_r;
  assign found    = |match_vec;
  assign full     = (count_r == CW'(CAPACITY));
  // Cells see the new value during compare, the latched one during update.
  assign cell_key = accept ? in_value : value_r;

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    refused   = 1'b0;
    count_nxt = count_r;
    if (busy_r) begin
      case (kind_r)
        KIND_INSERT: begin
          if (!found && !full) begin
            do_insert = 1'b1;
            count_nxt = count_r + CW'(1);
          end else if (!found) begin
            refused = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (found) begin
            do_remove = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
        default: begin
          // lookup: no change
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_ctrl_t       ctrl;
      logic [VAL_W-1:0] up_data;

      assign past_hit[gi] = |match_vec[gi:0];

      // Top cell has no neighbor above; its content goes stale past the count.
      if (gi == CAPACITY - 1) begin : g_top
        assign up_data = cell_data[gi];
      end else begin : g_mid
        assign up_data = cell_data[gi+1];
      end

      always_comb begin
        ctrl.cmp_en   = accept;
        ctrl.load_en  = do_insert && (count_r == CW'(gi));
        ctrl.shift_en = do_remove && past_hit[gi];
      end

      vsirl_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .live    (CW'(gi) < count_r),
        .key     (cell_key),
        .up_data (up_data),
        .data    (cell_data[gi]),
        .match   (match_vec[gi])
      );
    end
  endgenerate

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      count_r     <= count_nxt;
      out_valid_r <= busy_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_t'(in_kind);
      value_r <= in_value;
    end
    if (busy_r) begin
      out_found_r   <= found;
      out_count_r   <= COUNT_W'(count_nxt);
      out_refused_r <= refused;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_entry_count  = out_count_r;
  assign out_full_refused = out_refused_r;

endmodule

/* design/vsirl_cell.sv */
module vsirl_cell (
  input  logic                          clk,
  input  vsirl_pkg::cell_ctrl_t         ctrl,
  input  logic                          live,
  input  logic [vsirl_pkg::VAL_W-1:0]   key,
  input  logic [vsirl_pkg::VAL_W-1:0]   up_data,
  output logic [vsirl_pkg::VAL_W-1:0]   data,
  output logic                          match
);
  import vsirl_pkg::*;

  logic [VAL_W-1:0] data_r;
  logic             match_r;

  // Entry storage: append or shift down from the neighbor above.
  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      data_r <= key;
    end else if (ctrl.shift_en) begin
      data_r <= up_data;
    end
  end

  // Only occupied cells may report a hit.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match_r <= live && (data_r == key);
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule
